// File: rtl/ose_pkg.sv
package ose_pkg;

   localparam int STACK_DEPTH = 256;
   localparam int ADDR_W      = $clog2(STACK_DEPTH);
   localparam int HEIGHT_W    = ADDR_W + 1;
   localparam int WORD_W      = 64;
   localparam int OP_W        = 3;
   localparam int STATUS_W    = 2;

   localparam int REQ_FIELDS_W = WORD_W + HEIGHT_W;
   localparam int REQ_TDATA_W  = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_FIELDS_W = WORD_W + HEIGHT_W + STATUS_W;
   localparam int RSP_TDATA_W  = ((RSP_FIELDS_W + 7) / 8) * 8;
   localparam int REQ_TUSER_W  = 8;

   // Depth compared against a height that may have grown by two.
   localparam logic [HEIGHT_W:0] DEPTH_EXT = (HEIGHT_W + 1)'(STACK_DEPTH);

   typedef enum logic [OP_W-1:0] {
      OP_PUSH       = 3'd0,
      OP_POP        = 3'd1,
      OP_SWAP       = 3'd2,
      OP_SWAP_PAIRS = 3'd3,
      OP_ROTATE     = 3'd4,
      OP_DUP        = 3'd5,
      OP_DUP_PAIR   = 3'd6,
      OP_DROP       = 3'd7
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_UNDER = 2'd1,
      ST_OVER  = 2'd2
   } status_type;

   typedef struct packed {
      logic              en;
      logic              we;
      logic [ADDR_W-1:0] addr;
      logic [WORD_W-1:0] wdata;
   } ram_req_type;

   typedef struct packed {
      logic [WORD_W-1:0]   popped_value;
      logic [HEIGHT_W-1:0] stack_height;
      status_type          status;
   } result_type;

   // Number of stored elements read before any write.
   function automatic logic [2:0] op_reads(input op_type op);
      logic [2:0] n;
      case (op)
         OP_POP:        n = 3'd1;
         OP_SWAP:       n = 3'd2;
         OP_SWAP_PAIRS: n = 3'd4;
         OP_ROTATE:     n = 3'd3;
         OP_DUP:        n = 3'd1;
         OP_DUP_PAIR:   n = 3'd2;
         default:       n = 3'd0;
      endcase
      return n;
   endfunction

   function automatic logic [2:0] op_writes(input op_type op);
      logic [2:0] n;
      case (op)
         OP_PUSH:       n = 3'd1;
         OP_SWAP:       n = 3'd2;
         OP_SWAP_PAIRS: n = 3'd4;
         OP_ROTATE:     n = 3'd3;
         OP_DUP:        n = 3'd1;
         OP_DUP_PAIR:   n = 3'd2;
         default:       n = 3'd0;
      endcase
      return n;
   endfunction

   // Minimum height needed before the operation.
   function automatic logic [2:0] op_need(input op_type op);
      logic [2:0] n;
      case (op)
         OP_POP:        n = 3'd1;
         OP_SWAP:       n = 3'd2;
         OP_SWAP_PAIRS: n = 3'd4;
         OP_ROTATE:     n = 3'd3;
         OP_DUP:        n = 3'd1;
         OP_DUP_PAIR:   n = 3'd2;
         default:       n = 3'd0;
      endcase
      return n;
   endfunction

   function automatic logic [1:0] op_grow(input op_type op);
      logic [1:0] n;
      case (op)
         OP_PUSH:     n = 2'd1;
         OP_DUP:      n = 2'd1;
         OP_DUP_PAIR: n = 2'd2;
         default:     n = 2'd0;
      endcase
      return n;
   endfunction

   // Which captured word goes to write slot j. Read slot k holds the
   // element k places below the top.
   function automatic logic [1:0] op_wsrc(input op_type op, input logic [1:0] j);
      logic [1:0] s;
      case (op)
         OP_SWAP:       s = (j == 2'd0) ? 2'd1 : 2'd0;
         OP_SWAP_PAIRS: s = j ^ 2'd2;
         OP_ROTATE: begin
            case (j)
               2'd0:    s = 2'd1;
               2'd1:    s = 2'd2;
               default: s = 2'd0;
            endcase
         end
         OP_DUP_PAIR:   s = (j == 2'd0) ? 2'd1 : 2'd0;
         default:       s = 2'd0;
      endcase
      return s;
   endfunction

endpackage

// File: rtl/ose_ram.sv
module ose_ram (
   input  logic                       clock,
   input  ose_pkg::ram_req_type       ram_req,
   output logic [ose_pkg::WORD_W-1:0] rd_data
);

   logic [ose_pkg::WORD_W-1:0] mem [ose_pkg::STACK_DEPTH];
   logic [ose_pkg::WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ram_req.en) begin
         if (ram_req.we) begin
            mem[ram_req.addr] <= ram_req.wdata;
         end else begin
            rd_data_ff <= mem[ram_req.addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/ose_core.sv
module ose_core (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  ose_pkg::op_type              op,
   input  logic [ose_pkg::WORD_W-1:0]   push_value,
   input  logic [ose_pkg::HEIGHT_W-1:0] drop_count,
   output logic                         idle,
   input  logic                         res_free,
   output logic                         res_load,
   output ose_pkg::result_type          result,
   output ose_pkg::ram_req_type         ram_req,
   input  logic [ose_pkg::WORD_W-1:0]   rd_data
);

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_READ  = 5'b00010,
      S_DRAIN = 5'b00100,
      S_WRITE = 5'b01000,
      S_DONE  = 5'b10000
   } state_type;

   localparam int HW = ose_pkg::HEIGHT_W;
   localparam int AW = ose_pkg::ADDR_W;
   localparam int WW = ose_pkg::WORD_W;

   state_type              state_ff, state_in;
   logic [HW-1:0]          height_ff, height_in;
   logic [HW-1:0]          base_ff, base_in;
   ose_pkg::op_type        op_ff, op_in;
   ose_pkg::status_type    status_ff, status_in;
   logic [WW-1:0]          val_ff, val_in;
   logic [2:0]             nread_ff, nread_in;
   logic [2:0]             nwrite_ff, nwrite_in;
   logic [1:0]             step_ff, step_in;
   logic                   cap_ff, cap_in;
   logic [1:0]             cap_idx_ff, cap_idx_in;
   logic [WW-1:0]          buf_ff [4];

   logic [HW:0]            grown;
   logic                   under, over;
   ose_pkg::status_type    chk_status;
   logic [HW-1:0]          chk_height;
   logic [HW-1:0]          rd_ptr, wr_ptr;
   logic                   grows;

   // Checks made on the incoming operation against the current height.
   always_comb begin
      grown = {1'b0, height_ff} + (HW + 1)'(ose_pkg::op_grow(op));
      under = (height_ff < HW'(ose_pkg::op_need(op)));
      over  = (grown > ose_pkg::DEPTH_EXT);
      chk_height = height_ff;
      if (op == ose_pkg::OP_DROP) begin
         if (drop_count > height_ff) begin
            chk_status = ose_pkg::ST_UNDER;
            chk_height = '0;
         end else begin
            chk_status = ose_pkg::ST_OK;
            chk_height = height_ff - drop_count;
         end
      end else if (under) begin
         chk_status = ose_pkg::ST_UNDER;
      end else if (over) begin
         chk_status = ose_pkg::ST_OVER;
      end else begin
         chk_status = ose_pkg::ST_OK;
         if (op == ose_pkg::OP_POP) begin
            chk_height = height_ff - HW'(1);
         end else begin
            chk_height = grown[HW-1:0];
         end
      end
   end

   assign grows  = (op_ff == ose_pkg::OP_PUSH) || (op_ff == ose_pkg::OP_DUP) ||
                   (op_ff == ose_pkg::OP_DUP_PAIR);
   assign rd_ptr = base_ff - HW'(step_ff) - HW'(1);
   assign wr_ptr = grows ? (base_ff + HW'(step_ff)) : rd_ptr;

   always_comb begin
      state_in   = state_ff;
      height_in  = height_ff;
      base_in    = base_ff;
      op_in      = op_ff;
      status_in  = status_ff;
      val_in     = val_ff;
      nread_in   = nread_ff;
      nwrite_in  = nwrite_ff;
      step_in    = step_ff;
      cap_in     = 1'b0;
      cap_idx_in = step_ff;
      res_load   = 1'b0;
      ram_req    = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               base_in   = height_ff;
               height_in = chk_height;
               op_in     = op;
               status_in = chk_status;
               val_in    = push_value;
               nread_in  = ose_pkg::op_reads(op);
               nwrite_in = ose_pkg::op_writes(op);
               step_in   = '0;
               if (chk_status != ose_pkg::ST_OK) begin
                  state_in = S_DONE;
               end else if (ose_pkg::op_reads(op) != 3'd0) begin
                  state_in = S_READ;
               end else if (ose_pkg::op_writes(op) != 3'd0) begin
                  state_in = S_WRITE;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_READ: begin
            ram_req.en   = 1'b1;
            ram_req.addr = rd_ptr[AW-1:0];
            cap_in       = 1'b1;
            if ({1'b0, step_ff} == nread_ff - 3'd1) begin
               step_in  = '0;
               state_in = S_DRAIN;
            end else begin
               step_in = step_ff + 2'd1;
            end
         end
         S_DRAIN: begin
            // The last read word is captured at the end of this cycle.
            state_in = (nwrite_ff != 3'd0) ? S_WRITE : S_DONE;
         end
         S_WRITE: begin
            ram_req.en    = 1'b1;
            ram_req.we    = 1'b1;
            ram_req.addr  = wr_ptr[AW-1:0];
            ram_req.wdata = (op_ff == ose_pkg::OP_PUSH) ? val_ff
                            : buf_ff[ose_pkg::op_wsrc(op_ff, step_ff)];
            if ({1'b0, step_ff} == nwrite_ff - 3'd1) begin
               step_in  = '0;
               state_in = S_DONE;
            end else begin
               step_in = step_ff + 2'd1;
            end
         end
         S_DONE: begin
            if (res_free) begin
               res_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         height_ff <= '0;
         cap_ff    <= 1'b0;
      end else begin
         state_ff  <= state_in;
         height_ff <= height_in;
         cap_ff    <= cap_in;
      end
   end

   always_ff @(posedge clock) begin
      base_ff    <= base_in;
      op_ff      <= op_in;
      status_ff  <= status_in;
      val_ff     <= val_in;
      nread_ff   <= nread_in;
      nwrite_ff  <= nwrite_in;
      step_ff    <= step_in;
      cap_idx_ff <= cap_idx_in;
      if (cap_ff) begin
         buf_ff[cap_idx_ff] <= rd_data;
      end
   end

   assign idle = (state_ff == S_IDLE);

   always_comb begin
      result.popped_value = ((op_ff == ose_pkg::OP_POP) && (status_ff == ose_pkg::ST_OK))
                            ? buf_ff[0] : '0;
      result.stack_height = height_ff;
      result.status       = status_ff;
   end

endmodule

// File: rtl/operand_stack_engine_top.sv
// Operand stack engine: a last-in first-out stack of 64-bit words kept in a
// single-port memory of STACK_DEPTH entries.
// Request channel (req_): req_tuser carries the operation code, req_tdata the
// push word and the drop count. Every request produces exactly one response
// on the rsp_ channel with the popped word, the height after the operation
// and a status (ok, underflow or overflow).
// Timing: a request is taken only while the sequencer is idle. It then reads
// the touched elements one per cycle, passes through a drain state that
// collects the last read word when it read any, and writes the results back
// one per cycle. The sequencer returns to idle in the cycle after the
// response is loaded. Reads and writes go one at a time through the single
// memory port.
// The response sits in an output register, so the next request can be taken
// while a response still waits; if the receiver holds rsp_tready low, the
// sequencer finishes its current operation and then waits.
// Reset empties the stack (height zero) and drops any pending response; the
// memory contents are not cleared and need not be.
module operand_stack_engine_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [63:0] push_value, [72:64] drop_count, upper bits zero
   input  logic [ose_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // [2:0] operation, upper bits unused
   input  logic [ose_pkg::REQ_TUSER_W-1:0]   req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [63:0] popped_value, [72:64] stack_height, [74:73] status, upper bits zero
   output logic [ose_pkg::RSP_TDATA_W-1:0]   rsp_tdata
);

   localparam int WW = ose_pkg::WORD_W;
   localparam int HW = ose_pkg::HEIGHT_W;

   ose_pkg::ram_req_type ram_req;
   ose_pkg::result_type  result;
   logic [WW-1:0]        rd_data;
   logic                 idle;
   logic                 res_free;
   logic                 res_load;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [ose_pkg::RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;

   assign req_tready = idle;
   assign res_free   = !rsp_valid_ff || rsp_tready;

   ose_core u_core (
      .clock      (clock),
      .reset      (reset),
      .start      (req_tvalid && idle),
      .op         (ose_pkg::op_type'(req_tuser[ose_pkg::OP_W-1:0])),
      .push_value (req_tdata[WW-1:0]),
      .drop_count (req_tdata[WW+HW-1:WW]),
      .idle       (idle),
      .res_free   (res_free),
      .res_load   (res_load),
      .result     (result),
      .ram_req    (ram_req),
      .rd_data    (rd_data)
   );

   ose_ram u_ram (
      .clock   (clock),
      .ram_req (ram_req),
      .rd_data (rd_data)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = ose_pkg::RSP_TDATA_W'({result.status, result.stack_height,
                                               result.popped_value});
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// File: sim/operand_stack_engine_top_tb.sv
module operand_stack_engine_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int BUSY_PCT     = 31;
   localparam int RANDOM_ITEMS = 1700;
   localparam int REPORT_LIMIT = 10;

   // Shapes the random part: fill to the top, work near full, churn, drain,
   // and work near empty, then start over.
   typedef enum int {
      FILL_UP,
      NEAR_FULL,
      CHURN,
      DRAIN,
      NEAR_EMPTY
   } load_mode_type;

   class stack_scoreboard;
      logic [ose_pkg::WORD_W-1:0] words [ose_pkg::STACK_DEPTH];
      int                         height_now;
      ose_pkg::result_type        expected_q [$];
      int                         error_count;
      int                         result_count;

      function new();
         height_now   = 0;
         error_count  = 0;
         result_count = 0;
      endfunction

      function void swap_words(int a, int b);
         logic [ose_pkg::WORD_W-1:0] t;
         t        = words[a];
         words[a] = words[b];
         words[b] = t;
      endfunction

      function void note_error(string msg);
         error_count++;
         if (error_count <= REPORT_LIMIT) begin
            $display("ERROR at %0t: %s", $time, msg);
         end
      endfunction

      function int pending_count();
         return expected_q.size();
      endfunction

      // Applies one accepted request to the shadow stack and queues the
      // response it must produce.
      function void note_request(ose_pkg::op_type op,
                                 logic [ose_pkg::WORD_W-1:0] word,
                                 logic [ose_pkg::HEIGHT_W-1:0] count);
         ose_pkg::result_type r;
         int                  h;
         int                  c;
         h              = height_now;
         c              = int'(count);
         r.popped_value = '0;
         r.status       = ose_pkg::ST_OK;
         case (op)
            ose_pkg::OP_PUSH: begin
               if (h >= ose_pkg::STACK_DEPTH) begin
                  r.status = ose_pkg::ST_OVER;
               end else begin
                  words[h]   = word;
                  height_now = h + 1;
               end
            end
            ose_pkg::OP_POP: begin
               if (h < 1) begin
                  r.status = ose_pkg::ST_UNDER;
               end else begin
                  height_now     = h - 1;
                  r.popped_value = words[h - 1];
               end
            end
            ose_pkg::OP_SWAP: begin
               if (h < 2) r.status = ose_pkg::ST_UNDER;
               else swap_words(h - 2, h - 1);
            end
            ose_pkg::OP_SWAP_PAIRS: begin
               if (h < 4) begin
                  r.status = ose_pkg::ST_UNDER;
               end else begin
                  swap_words(h - 3, h - 1);
                  swap_words(h - 4, h - 2);
               end
            end
            ose_pkg::OP_ROTATE: begin
               if (h < 3) begin
                  r.status = ose_pkg::ST_UNDER;
               end else begin
                  swap_words(h - 1, h - 2);
                  swap_words(h - 2, h - 3);
               end
            end
            ose_pkg::OP_DUP: begin
               if (h < 1) begin
                  r.status = ose_pkg::ST_UNDER;
               end else if (h + 1 > ose_pkg::STACK_DEPTH) begin
                  r.status = ose_pkg::ST_OVER;
               end else begin
                  words[h]   = words[h - 1];
                  height_now = h + 1;
               end
            end
            ose_pkg::OP_DUP_PAIR: begin
               // The underflow check wins over the overflow check.
               if (h < 2) begin
                  r.status = ose_pkg::ST_UNDER;
               end else if (h + 2 > ose_pkg::STACK_DEPTH) begin
                  r.status = ose_pkg::ST_OVER;
               end else begin
                  words[h]     = words[h - 2];
                  words[h + 1] = words[h - 1];
                  height_now   = h + 2;
               end
            end
            default: begin
               // Dropping more than is held empties the stack anyway.
               if (c > h) begin
                  height_now = 0;
                  r.status   = ose_pkg::ST_UNDER;
               end else begin
                  height_now = h - c;
               end
            end
         endcase
         r.stack_height = ose_pkg::HEIGHT_W'(height_now);
         expected_q     = {expected_q, r};
      endfunction

      function void check_response(logic [ose_pkg::RSP_TDATA_W-1:0] tdata);
         ose_pkg::result_type             want;
         logic [ose_pkg::WORD_W-1:0]      got_word;
         logic [ose_pkg::HEIGHT_W-1:0]    got_height;
         logic [ose_pkg::STATUS_W-1:0]    got_status;
         logic [ose_pkg::RSP_TDATA_W-1:0] pad;
         got_word   = tdata[ose_pkg::WORD_W-1:0];
         got_height = tdata[ose_pkg::WORD_W +: ose_pkg::HEIGHT_W];
         got_status = tdata[ose_pkg::WORD_W + ose_pkg::HEIGHT_W +: ose_pkg::STATUS_W];
         pad        = tdata >> (ose_pkg::WORD_W + ose_pkg::HEIGHT_W + ose_pkg::STATUS_W);
         if (expected_q.size() == 0) begin
            note_error($sformatf("response %h with no request outstanding", tdata));
            return;
         end
         want = expected_q.pop_front();
         if (got_word !== want.popped_value || got_height !== want.stack_height ||
             got_status !== want.status || pad !== '0) begin
            note_error($sformatf(
               "response %0d: expected word %h height %0d status %0d, got %h %0d %0d pad %h",
               result_count, want.popped_value, want.stack_height, want.status,
               got_word, got_height, got_status, pad));
         end
         result_count++;
      endfunction
   endclass

   logic                            clock = 1'b0;
   logic                            reset;
   logic                            req_tvalid;
   logic                            req_tready;
   logic [ose_pkg::REQ_TDATA_W-1:0] req_tdata;
   logic [ose_pkg::REQ_TUSER_W-1:0] req_tuser;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [ose_pkg::RSP_TDATA_W-1:0] rsp_tdata;

   // While set, neither side inserts idle cycles.
   bit                              steady = 1'b0;
   stack_scoreboard                 sb;

   operand_stack_engine_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_response(rsp_tdata);
      end
      rsp_tready <= steady || ($urandom_range(99) >= BUSY_PCT);
   end

   // Called at a rising edge; returns at the edge where the transfer happened.
   task automatic send_request(input ose_pkg::op_type op,
                               input logic [ose_pkg::WORD_W-1:0] word,
                               input logic [ose_pkg::HEIGHT_W-1:0] count);
      logic [ose_pkg::REQ_TDATA_W-1:0] data;
      logic [ose_pkg::REQ_TUSER_W-1:0] user;
      data                                     = '0;
      data[ose_pkg::WORD_W-1:0]                = word;
      data[ose_pkg::WORD_W +: ose_pkg::HEIGHT_W] = count;
      user                                     = '0;
      user[ose_pkg::OP_W-1:0]                  = op;
      if (!steady && $urandom_range(99) < BUSY_PCT) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < BUSY_PCT);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tuser  <= user;
      do @(posedge clock); while (!req_tready);
      sb.note_request(op, word, count);
   endtask

   function automatic logic [ose_pkg::WORD_W-1:0] pick_word();
      int r = $urandom_range(99);
      if (r < 10) return '1;
      if (r < 20) return '0;
      if (r < 30) return 64'd1 << $urandom_range(ose_pkg::WORD_W - 1);
      return {$urandom, $urandom};
   endfunction

   function automatic logic [ose_pkg::HEIGHT_W-1:0] pick_count(int h);
      int r = $urandom_range(99);
      if (r < 50) return ose_pkg::HEIGHT_W'($urandom_range(3));
      if (r < 65) return ose_pkg::HEIGHT_W'(h);
      if (r < 75) return ose_pkg::HEIGHT_W'((h < ose_pkg::STACK_DEPTH) ? h + 1 : h);
      if (r < 85) return ose_pkg::HEIGHT_W'(ose_pkg::STACK_DEPTH);
      return ose_pkg::HEIGHT_W'($urandom_range(ose_pkg::STACK_DEPTH));
   endfunction

   function automatic ose_pkg::op_type pick_op(load_mode_type mode);
      int r = $urandom_range(99);
      case (mode)
         FILL_UP, NEAR_FULL: begin
            if (r < 60) return ose_pkg::OP_PUSH;
            if (r < 78) return ose_pkg::OP_DUP;
            if (r < 93) return ose_pkg::OP_DUP_PAIR;
         end
         DRAIN: begin
            if (r < 45) return ose_pkg::OP_POP;
            if (r < 65) return ose_pkg::OP_DROP;
         end
         default: ;
      endcase
      return ose_pkg::op_type'($urandom_range(7));
   endfunction

   task automatic run_random();
      load_mode_type mode;
      int            burst;
      int            h;
      mode  = FILL_UP;
      burst = 0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         steady = (n >= 700 && n < 1000);
         h      = sb.height_now;
         case (mode)
            FILL_UP: begin
               if (h >= ose_pkg::STACK_DEPTH) begin
                  mode  = NEAR_FULL;
                  burst = 12;
               end
            end
            NEAR_FULL: begin
               if (burst == 0) begin
                  mode  = CHURN;
                  burst = $urandom_range(40, 80);
               end
            end
            CHURN: begin
               if (burst == 0) mode = DRAIN;
            end
            DRAIN: begin
               if (h <= 2) begin
                  mode  = NEAR_EMPTY;
                  burst = 20;
               end
            end
            default: begin
               if (burst == 0) mode = FILL_UP;
            end
         endcase
         send_request(pick_op(mode), pick_word(), pick_count(h));
         if (burst > 0) burst--;
      end
      steady = 1'b0;
   endtask

   initial begin
      sb         = new();
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Every operation on an empty stack, then each one with enough operands.
      send_request(ose_pkg::OP_POP,        '1, '0);
      send_request(ose_pkg::OP_SWAP,       '1, '0);
      send_request(ose_pkg::OP_SWAP_PAIRS, '1, '0);
      send_request(ose_pkg::OP_ROTATE,     '1, '0);
      send_request(ose_pkg::OP_DUP,        '1, '0);
      send_request(ose_pkg::OP_DUP_PAIR,   '1, '0);
      send_request(ose_pkg::OP_DROP,       '1, '0);
      send_request(ose_pkg::OP_DROP,       '0, ose_pkg::HEIGHT_W'(ose_pkg::STACK_DEPTH));
      send_request(ose_pkg::OP_PUSH,       '0, '1);
      send_request(ose_pkg::OP_PUSH,       '1, '0);
      send_request(ose_pkg::OP_SWAP_PAIRS, '0, '0);
      send_request(ose_pkg::OP_DUP_PAIR,   '0, '0);
      send_request(ose_pkg::OP_SWAP_PAIRS, '0, '0);
      send_request(ose_pkg::OP_PUSH,       64'h0123_4567_89ab_cdef, '0);
      send_request(ose_pkg::OP_SWAP,       '0, '0);
      send_request(ose_pkg::OP_ROTATE,     '0, '0);
      send_request(ose_pkg::OP_DUP,        '0, '0);
      send_request(ose_pkg::OP_POP,        '0, '0);
      send_request(ose_pkg::OP_POP,        '0, '0);
      send_request(ose_pkg::OP_DROP,       '0, 9'd2);
      send_request(ose_pkg::OP_DROP,       '0, '0);
      send_request(ose_pkg::OP_DROP,       '0, ose_pkg::HEIGHT_W'(ose_pkg::STACK_DEPTH));
      send_request(ose_pkg::OP_PUSH,       64'h8000_0000_0000_0001, '0);
      send_request(ose_pkg::OP_POP,        '0, '0);
      send_request(ose_pkg::OP_POP,        '0, '0);

      run_random();
      req_tvalid <= 1'b0;

      while (sb.pending_count() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      if (sb.error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Timeout waiting for the stack engine");
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
